@@ hdl/ihex_pkg.sv @@
package ihex_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int BUF_DEPTH    = 16;
  localparam int IDX_W        = $clog2(BUF_DEPTH);
  localparam int CNT_W        = IDX_W + 1;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_EOF   = 2'd3;

  localparam logic [7:0]  CH_COLON  = 8'h3A;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  TYPE_DATA = 8'h00;
  localparam logic [7:0]  TYPE_EOF  = 8'h01;
  localparam logic [7:0]  TYPE_ELA  = 8'h04;
  localparam logic [7:0]  ELA_LEN   = 8'h02;
  localparam logic [15:0] PAGE_LAST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ELA,
    KIND_DATA,
    KIND_EOF
  } kind_t;

  typedef enum logic [2:0] {
    FLD_COLON,
    FLD_LEN,
    FLD_AHI,
    FLD_ALO,
    FLD_TYPE,
    FLD_DATA,
    FLD_CSUM,
    FLD_LF
  } field_t;

  typedef struct packed {
    logic   take;
    logic   emit;
    field_t field;
    logic   lo;
    logic   last;
    logic   sum_add;
    logic   idx_inc;
    logic   kind_load;
    kind_t  kind;
    logic   rec_end;
  } ctl_t;

  typedef struct packed {
    logic  out_free;
    logic  eof_req;
    logic  flush_req;
    logic  ela_req;
    logic  data_last;
    logic  len_zero;
    kind_t kind;
  } sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'b0, n};
    end else begin
      c = 8'h37 + {4'b0, n};
    end
    return c;
  endfunction

endpackage

@@ hdl/ihex_ctrl.sv @@
module ihex_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ihex_pkg::sts_t sts,
  output ihex_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_COLON,
    S_LEN,
    S_AHI,
    S_ALO,
    S_TYPE,
    S_DATA,
    S_CSUM,
    S_LF
  } state_t;

  state_t state, state_next;
  logic   lo, lo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lo    <= 1'b0;
    end else begin
      state <= state_next;
      lo    <= lo_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    lo_next       = lo;
    ctl           = '0;
    ctl.field     = ihex_pkg::FLD_COLON;
    ctl.kind      = ihex_pkg::KIND_DATA;
    ctl.lo        = lo;
    unique case (state) inside
      S_IDLE: begin
        ctl.take = in_valid;
        lo_next  = 1'b0;
        if (in_valid) begin
          if (sts.eof_req) begin
            ctl.kind_load = 1'b1;
            ctl.kind      = ihex_pkg::KIND_EOF;
            state_next    = S_COLON;
          end else if (sts.flush_req) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        ctl.kind_load = 1'b1;
        ctl.kind      = sts.ela_req ? ihex_pkg::KIND_ELA : ihex_pkg::KIND_DATA;
        state_next    = S_COLON;
      end
      S_COLON: begin
        ctl.field = ihex_pkg::FLD_COLON;
        ctl.emit  = sts.out_free;
        if (sts.out_free) state_next = S_LEN;
      end
      S_LEN, S_AHI, S_ALO, S_TYPE, S_DATA, S_CSUM: begin
        unique case (state)
          S_LEN:   ctl.field = ihex_pkg::FLD_LEN;
          S_AHI:   ctl.field = ihex_pkg::FLD_AHI;
          S_ALO:   ctl.field = ihex_pkg::FLD_ALO;
          S_TYPE:  ctl.field = ihex_pkg::FLD_TYPE;
          S_DATA:  ctl.field = ihex_pkg::FLD_DATA;
          default: ctl.field = ihex_pkg::FLD_CSUM;
        endcase
        ctl.emit    = sts.out_free;
        ctl.sum_add = lo && (state != S_CSUM);
        if (sts.out_free) begin
          lo_next = !lo;
          if (lo) begin
            unique case (state)
              S_LEN:  state_next = S_AHI;
              S_AHI:  state_next = S_ALO;
              S_ALO:  state_next = S_TYPE;
              S_TYPE: state_next = sts.len_zero ? S_CSUM : S_DATA;
              S_DATA: begin
                if (sts.data_last) begin
                  state_next = S_CSUM;
                end else begin
                  ctl.idx_inc = 1'b1;
                end
              end
              default: state_next = S_LF;
            endcase
          end
        end
      end
      S_LF: begin
        ctl.field   = ihex_pkg::FLD_LF;
        ctl.emit    = sts.out_free;
        ctl.rec_end = sts.out_free;
        ctl.last    = (sts.kind != ihex_pkg::KIND_ELA);
        if (sts.out_free) begin
          if (sts.kind == ihex_pkg::KIND_ELA) begin
            ctl.kind_load = 1'b1;
            ctl.kind      = ihex_pkg::KIND_DATA;
            state_next    = S_COLON;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> sts.out_free)
    else $error("word emitted while output register busy");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && !sts.eof_req && !sts.flush_req) |=> (state == S_IDLE))
    else $error("item with no output left the idle state");

  a_flush_colon: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (state == S_COLON))
    else $error("flush did not start a record");
`endif

endmodule

@@ hdl/ihex_dp.sv @@
module ihex_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     cmd,
  input  logic [31:0]    address,
  input  logic [7:0]     data_byte,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [7:0]     character,
  output logic           last,
  input  ihex_pkg::ctl_t ctl,
  output ihex_pkg::sts_t sts
);

  logic [7:0]                   buffer [ihex_pkg::BUF_DEPTH];
  logic [ihex_pkg::CNT_W-1:0]   count;
  logic [31:0]                  rec_start;
  logic [31:0]                  next_addr;
  logic [15:0]                  upper;
  logic                         upper_valid;
  ihex_pkg::kind_t              kind;
  logic [ihex_pkg::IDX_W-1:0]   idx;
  logic [7:0]                   sum;

  logic [ihex_pkg::CNT_W-1:0]   count_inc;
  logic [ihex_pkg::CNT_W-1:0]   len;
  logic [7:0]                   cur_byte;
  logic [3:0]                   nib;
  logic [7:0]                   char_next;

  assign count_inc = count + ihex_pkg::CNT_W'(1);

  always_comb begin
    unique case (kind)
      ihex_pkg::KIND_ELA:  len = ihex_pkg::CNT_W'(ihex_pkg::ELA_LEN);
      ihex_pkg::KIND_DATA: len = count;
      default:             len = '0;
    endcase
  end

  always_comb begin
    sts.out_free  = !out_valid || out_ready;
    sts.eof_req   = (cmd == ihex_pkg::CMD_EOF);
    sts.kind      = kind;
    sts.len_zero  = (len == '0);
    sts.data_last = ({1'b0, idx} + ihex_pkg::CNT_W'(1)) == len;
    sts.ela_req   = !upper_valid || (upper != rec_start[31:16]);
    unique case (cmd) inside
      ihex_pkg::CMD_DATA:
        sts.flush_req = (count_inc >= ihex_pkg::CNT_W'(ihex_pkg::RECORD_BYTES))
                        || (next_addr[15:0] == ihex_pkg::PAGE_LAST);
      ihex_pkg::CMD_START, ihex_pkg::CMD_END:
        sts.flush_req = (count != '0);
      default:
        sts.flush_req = 1'b0;
    endcase
  end

  always_comb begin
    cur_byte = '0;
    case (ctl.field)
      ihex_pkg::FLD_LEN:  cur_byte = 8'(len);
      ihex_pkg::FLD_AHI:  cur_byte = (kind == ihex_pkg::KIND_DATA) ? rec_start[15:8] : 8'h00;
      ihex_pkg::FLD_ALO:  cur_byte = (kind == ihex_pkg::KIND_DATA) ? rec_start[7:0] : 8'h00;
      ihex_pkg::FLD_TYPE: begin
        unique case (kind)
          ihex_pkg::KIND_ELA:  cur_byte = ihex_pkg::TYPE_ELA;
          ihex_pkg::KIND_DATA: cur_byte = ihex_pkg::TYPE_DATA;
          default:             cur_byte = ihex_pkg::TYPE_EOF;
        endcase
      end
      ihex_pkg::FLD_DATA: begin
        if (kind == ihex_pkg::KIND_ELA) begin
          cur_byte = idx[0] ? rec_start[23:16] : rec_start[31:24];
        end else begin
          cur_byte = buffer[idx];
        end
      end
      ihex_pkg::FLD_CSUM: cur_byte = 8'h00 - sum;
      default:            cur_byte = '0;
    endcase
    nib = ctl.lo ? cur_byte[3:0] : cur_byte[7:4];
    case (ctl.field)
      ihex_pkg::FLD_COLON: char_next = ihex_pkg::CH_COLON;
      ihex_pkg::FLD_LF:    char_next = ihex_pkg::CH_LF;
      default:             char_next = ihex_pkg::hex_char(nib);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      count       <= '0;
      rec_start   <= '0;
      next_addr   <= '0;
      upper       <= '0;
      upper_valid <= 1'b0;
      kind        <= ihex_pkg::KIND_DATA;
      idx         <= '0;
      sum         <= '0;
    end else begin
      if (ctl.emit) begin
        out_valid <= 1'b1;
        character <= char_next;
        last      <= ctl.last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (ctl.take) begin
        unique case (cmd)
          ihex_pkg::CMD_START: next_addr <= address;
          ihex_pkg::CMD_DATA: begin
            buffer[count[ihex_pkg::IDX_W-1:0]] <= data_byte;
            count     <= count_inc;
            next_addr <= next_addr + 32'd1;
            if (count == '0) rec_start <= next_addr;
          end
          ihex_pkg::CMD_EOF: begin
            count       <= '0;
            upper       <= '0;
            upper_valid <= 1'b0;
          end
          default: ;
        endcase
      end

      if (ctl.rec_end) begin
        if (kind == ihex_pkg::KIND_ELA) begin
          upper       <= rec_start[31:16];
          upper_valid <= 1'b1;
        end else if (kind == ihex_pkg::KIND_DATA) begin
          count <= '0;
        end
      end

      if (ctl.kind_load) begin
        kind <= ctl.kind;
        idx  <= '0;
        sum  <= '0;
      end else begin
        if (ctl.emit && ctl.sum_add) sum <= sum + cur_byte;
        if (ctl.idx_inc) idx <= idx + ihex_pkg::IDX_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= ihex_pkg::CNT_W'(ihex_pkg::RECORD_BYTES))
    else $error("buffer count beyond record size");

  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (ctl.kind_load && (ctl.kind == ihex_pkg::KIND_DATA)) |-> (count != '0))
    else $error("data record started with empty buffer");

  a_ela_needed: assert property (@(posedge clk) disable iff (rst)
    (ctl.kind_load && (ctl.kind == ihex_pkg::KIND_ELA))
      |-> (!upper_valid || (upper != rec_start[31:16])))
    else $error("extended address record not needed");
`endif

endmodule

@@ hdl/intel_hex_record_encoder.sv @@
// Intel HEX writer: takes one command word at a time (start segment, data byte, end segment,
// end of file) and sends the HEX text one ASCII character per output word, with last set
// on the final character caused by the command. Data bytes collect into records of up to
// 16 bytes; a data byte that neither fills the record nor ends a 64K page gives no output.
// A command that emits a record is decided in the idle state, passes a flush state when
// buffered bytes are to go out (not for end of file), then sends its characters through
// the single character output register: 12 + 2n characters for an n-byte data record,
// 16 more when an extended address record comes first, 12 for the end-of-file record.
// The output register holds a character while out_ready is low. A new command is taken
// only once the previous one has issued all of its characters.
module intel_hex_record_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] address,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last
);

  ihex_pkg::ctl_t ctl;
  ihex_pkg::sts_t sts;

  ihex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ihex_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .address   (address),
    .data_byte (data_byte),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .character (character),
    .last      (last),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
